// ----- rtl/sahtr_pkg.sv -----
// shared types and constants for the set-associative position table
package sahtr_pkg;

    localparam int KEY_W  = 64;
    localparam int TAG_W  = 32;
    localparam int GEN_W  = 16;
    localparam int VAL_W  = 16;
    // replace value: depth minus four times the age gap, fits in 20 bits signed
    localparam int RV_W   = 20;
    localparam int REL_W  = GEN_W + 1;
    localparam int AGE_SHIFT = 2;
    localparam int DEPTH_MARGIN = 4;

    localparam logic FUNC_PROBE = 1'b0;
    localparam logic FUNC_SAVE  = 1'b1;

    localparam logic [1:0] BND_NONE  = 2'd0;
    localparam logic [1:0] BND_UPPER = 2'd1;
    localparam logic [1:0] BND_LOWER = 2'd2;
    localparam logic [1:0] BND_EXACT = 2'd3;

    typedef struct packed {
        logic                    func;
        logic [KEY_W-1:0]        key;
        logic signed [VAL_W-1:0] score;
        logic signed [VAL_W-1:0] static_eval;
        logic                    pv_flag;
        logic [1:0]              bound_kind;
        logic signed [VAL_W-1:0] search_depth;
        logic [VAL_W-1:0]        best_move;
    } req_t;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] hit_score;
        logic signed [VAL_W-1:0] hit_eval;
        logic [VAL_W-1:0]        hit_move;
        logic signed [VAL_W-1:0] hit_depth;
        logic [1:0]              hit_bound;
        logic                    hit_pv;
    } rsp_t;

    typedef struct packed {
        logic [TAG_W-1:0]        tag;
        logic [GEN_W-1:0]        age;
        logic signed [VAL_W-1:0] score;
        logic signed [VAL_W-1:0] static_eval;
        logic [VAL_W-1:0]        move;
        logic signed [VAL_W-1:0] depth;
        logic                    pv;
        logic [1:0]              bound;
    } entry_t;

endpackage

// ----- rtl/set_assoc_hash_table_depth_age_replace_unit.sv -----
// set-associative position table with depth/age replacement, top level
//
// After reset the block sweeps the table clear, one cluster row per cycle, and
// stays busy until every row is cleared. A request is taken when start is high
// and busy is low; its result shows on rsp with done, which is high for a
// single cycle, and cannot be held off. With CLUSTERS a power of two the
// cluster is the low key bits and a probe passes through a row read, then a
// decide and write back. A save that finds an empty or matching way reads the
// row, decides and writes; a save that must evict also steps through the ways,
// since one shared replace-value unit walks the ways one per cycle. For other
// CLUSTERS values the cluster index is the key modulo CLUSTERS: a shared
// multiply-accumulate folds one key byte per cycle, then a reciprocal estimate
// and compare-subtract steps reduce the sum before the row read of every
// request. A new start is taken in the cycle the previous result is shown.
module set_assoc_hash_table_depth_age_replace_unit #(
    parameter int CLUSTERS = 1024,
    parameter int WAYS     = 3
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  sahtr_pkg::req_t                   req,
    output logic                              busy,
    output logic                              done,
    output sahtr_pkg::rsp_t                   rsp,
    input  logic                              cfg_we,
    input  logic [sahtr_pkg::GEN_W-1:0]       cfg_wdata
);

    localparam int  IW      = $clog2(CLUSTERS);
    localparam int  WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam bit  IS_POW2 = ((CLUSTERS & (CLUSTERS - 1)) == 0);
    localparam int  NBYTES  = sahtr_pkg::KEY_W / 8;
    localparam int  BCW     = $clog2(NBYTES);
    // quotient estimate width; the byte sum stays below 2^(IW+QW-1)
    localparam int  QW      = 12;
    localparam int  AW      = IW + QW - 1;
    localparam int  VAL_EXT_W = sahtr_pkg::VAL_W + 1;
    localparam logic [QW-1:0] RECIP = QW'((64'd1 << (IW - 1 + QW)) / 64'(CLUSTERS));

    // weight of key byte i is 256^i modulo CLUSTERS
    function automatic logic [NBYTES*IW-1:0] byte_weights();
        logic [NBYTES*IW-1:0] wts;
        longint unsigned      pw;
        wts = '0;
        pw  = 1;
        for (int i = 0; i < NBYTES; i++)
        begin
            wts[i*IW +: IW] = IW'(pw);
            for (int s = 0; s < 8; s++)
            begin
                pw = pw << 1;
                if (pw >= longint'(CLUSTERS))
                begin
                    pw = pw - longint'(CLUSTERS);
                end
            end
        end
        return wts;
    endfunction

    localparam logic [NBYTES*IW-1:0] BYTE_WT = byte_weights();

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_QEST,
        ST_FOLD,
        ST_FIX,
        ST_READ,
        ST_EVAL,
        ST_REPL,
        ST_WRITE
    } state_t;

    state_t                          state_reg, state_next;
    sahtr_pkg::req_t                 req_reg, req_next;
    logic [IW-1:0]                   idx_reg, idx_next;
    logic [AW-1:0]                   acc_reg, acc_next;
    logic [BCW-1:0]                  byte_cnt_reg, byte_cnt_next;
    logic [QW-1:0]                   quo_reg, quo_next;
    logic [IW-1:0]                   clr_cnt_reg, clr_cnt_next;
    logic [WW-1:0]                   sel_reg, sel_next;
    logic [WW-1:0]                   way_reg, way_next;
    logic signed [sahtr_pkg::RV_W-1:0] best_val_reg, best_val_next;
    logic                            done_reg, done_next;
    sahtr_pkg::rsp_t                 rsp_reg, rsp_next;
    logic [sahtr_pkg::GEN_W-1:0]     gen_reg;

    sahtr_pkg::entry_t [WAYS-1:0]    mem [CLUSTERS];
    sahtr_pkg::entry_t [WAYS-1:0]    rd_row_reg;

    logic                            mem_we;
    logic [IW-1:0]                   mem_addr;
    sahtr_pkg::entry_t [WAYS-1:0]    mem_row;

    logic [sahtr_pkg::TAG_W-1:0]     key_tag;
    logic                            fw_found;
    logic [WW-1:0]                   fw_idx;
    logic                            probe_hit;
    sahtr_pkg::entry_t               hit_ent;

    logic [WW-1:0]                   rv_sel;
    sahtr_pkg::entry_t               rv_ent;
    logic signed [sahtr_pkg::REL_W-1:0] rv_rel;
    logic signed [sahtr_pkg::RV_W-1:0]  rv_val;

    logic [7:0]                      key_byte;
    logic [IW-1:0]                   byte_wt;
    logic [AW-1:0]                   mac_sum;
    logic [QW-1:0]                   quo_in;
    logic [2*QW-1:0]                 quo_prod;
    logic [QW-1:0]                   quo_est;
    logic [AW-1:0]                   fold_val;

    sahtr_pkg::entry_t               old_ent;
    sahtr_pkg::entry_t               new_ent;
    logic                            tag_differs;
    logic signed [VAL_EXT_W-1:0]     new_depth_ext;
    logic signed [VAL_EXT_W-1:0]     old_depth_lim;
    logic                            deeper;

    assign key_tag = req_reg.key[sahtr_pkg::KEY_W-1 -: sahtr_pkg::TAG_W];

    // first way that is empty or carries the key's tag
    always_comb
    begin
        fw_found = 1'b0;
        fw_idx   = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (rd_row_reg[w].tag == '0 || rd_row_reg[w].tag == key_tag)
            begin
                fw_found = 1'b1;
                fw_idx   = WW'(w);
            end
        end
    end

    assign hit_ent   = rd_row_reg[fw_idx];
    assign probe_hit = fw_found && (hit_ent.tag != '0);

    // shared replace-value unit, one way per cycle
    assign rv_sel = (state_reg == ST_REPL) ? way_reg : '0;
    assign rv_ent = rd_row_reg[rv_sel];
    assign rv_rel = $signed({1'b0, gen_reg}) - $signed({1'b0, rv_ent.age});
    assign rv_val = sahtr_pkg::RV_W'(rv_ent.depth)
                  - (sahtr_pkg::RV_W'(rv_rel) <<< sahtr_pkg::AGE_SHIFT);

    // key modulo CLUSTERS: byte multiply-accumulate, then reciprocal estimate
    // that is low by at most two, then compare-subtract
    assign key_byte = req_reg.key[{byte_cnt_reg, 3'b000} +: 8];
    assign byte_wt  = BYTE_WT[byte_cnt_reg * IW +: IW];
    assign mac_sum  = acc_reg + AW'(key_byte) * AW'(byte_wt);
    assign quo_in   = QW'(acc_reg >> (IW - 1));
    assign quo_prod = (2*QW)'(quo_in) * (2*QW)'(RECIP);
    assign quo_est  = quo_prod[2*QW-1:QW];
    assign fold_val = acc_reg - AW'(quo_reg) * AW'(CLUSTERS);

    // save merge into the chosen way
    always_comb
    begin
        old_ent       = rd_row_reg[sel_reg];
        new_ent       = old_ent;
        tag_differs   = (old_ent.tag != key_tag);
        new_depth_ext = VAL_EXT_W'(req_reg.search_depth);
        old_depth_lim = VAL_EXT_W'(old_ent.depth) - VAL_EXT_W'(sahtr_pkg::DEPTH_MARGIN);
        deeper        = (new_depth_ext > old_depth_lim);
        if (req_reg.best_move != '0 || tag_differs)
        begin
            new_ent.move = req_reg.best_move;
        end
        if (tag_differs || req_reg.bound_kind == sahtr_pkg::BND_EXACT || deeper)
        begin
            new_ent.tag         = key_tag;
            new_ent.age         = gen_reg;
            new_ent.score       = req_reg.score;
            new_ent.static_eval = req_reg.static_eval;
            new_ent.depth       = req_reg.search_depth;
            new_ent.pv          = req_reg.pv_flag;
            new_ent.bound       = req_reg.bound_kind;
        end
    end

    // memory write port
    always_comb
    begin
        mem_we   = 1'b0;
        mem_addr = idx_reg;
        mem_row  = rd_row_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_cnt_reg;
                mem_row  = '0;
            end
            ST_EVAL:
            begin
                if (req_reg.func == sahtr_pkg::FUNC_PROBE && probe_hit)
                begin
                    mem_we              = 1'b1;
                    mem_row[fw_idx].age = gen_reg;
                end
            end
            ST_WRITE:
            begin
                mem_we           = 1'b1;
                mem_row[sel_reg] = new_ent;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_row;
        end
        if (state_reg == ST_READ)
        begin
            rd_row_reg <= mem[idx_reg];
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        byte_cnt_next = byte_cnt_reg;
        quo_next      = quo_reg;
        clr_cnt_next  = clr_cnt_reg;
        sel_next      = sel_reg;
        way_next      = way_reg;
        best_val_next = best_val_reg;
        done_next     = 1'b0;
        rsp_next      = rsp_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IW'(CLUSTERS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    if (IS_POW2)
                    begin
                        idx_next   = req.key[IW-1:0];
                        state_next = ST_READ;
                    end
                    else
                    begin
                        acc_next      = '0;
                        byte_cnt_next = '0;
                        state_next    = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                acc_next      = mac_sum;
                byte_cnt_next = byte_cnt_reg + 1'b1;
                if (byte_cnt_reg == BCW'(NBYTES - 1))
                begin
                    state_next = ST_QEST;
                end
            end
            ST_QEST:
            begin
                quo_next   = quo_est;
                state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                acc_next   = fold_val;
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                if (acc_reg >= AW'(CLUSTERS))
                begin
                    acc_next = acc_reg - AW'(CLUSTERS);
                end
                else
                begin
                    idx_next   = acc_reg[IW-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (req_reg.func == sahtr_pkg::FUNC_PROBE)
                begin
                    done_next = 1'b1;
                    rsp_next  = '0;
                    if (probe_hit)
                    begin
                        rsp_next.hit       = 1'b1;
                        rsp_next.hit_score = hit_ent.score;
                        rsp_next.hit_eval  = hit_ent.static_eval;
                        rsp_next.hit_move  = hit_ent.move;
                        rsp_next.hit_depth = hit_ent.depth;
                        rsp_next.hit_bound = hit_ent.bound;
                        rsp_next.hit_pv    = hit_ent.pv;
                    end
                    state_next = ST_IDLE;
                end
                else if (fw_found)
                begin
                    sel_next   = fw_idx;
                    state_next = ST_WRITE;
                end
                else if (WAYS == 1)
                begin
                    sel_next   = '0;
                    state_next = ST_WRITE;
                end
                else
                begin
                    sel_next      = '0;
                    best_val_next = rv_val;
                    way_next      = WW'(1);
                    state_next    = ST_REPL;
                end
            end
            ST_REPL:
            begin
                // strict compare keeps the earliest way on a tie
                if (best_val_reg > rv_val)
                begin
                    sel_next      = way_reg;
                    best_val_next = rv_val;
                end
                if (way_reg == WW'(WAYS - 1))
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    way_next = way_reg + 1'b1;
                end
            end
            ST_WRITE:
            begin
                done_next  = 1'b1;
                rsp_next   = '0;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            req_reg      <= '0;
            idx_reg      <= '0;
            acc_reg      <= '0;
            byte_cnt_reg <= '0;
            quo_reg      <= '0;
            clr_cnt_reg  <= '0;
            sel_reg      <= '0;
            way_reg      <= '0;
            best_val_reg <= '0;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            req_reg      <= req_next;
            idx_reg      <= idx_next;
            acc_reg      <= acc_next;
            byte_cnt_reg <= byte_cnt_next;
            quo_reg      <= quo_next;
            clr_cnt_reg  <= clr_cnt_next;
            sel_reg      <= sel_next;
            way_reg      <= way_next;
            best_val_reg <= best_val_next;
            done_reg     <= done_next;
            rsp_reg      <= rsp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= '0;
        end
        else if (cfg_we)
        begin
            gen_reg <= cfg_wdata;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    // a result is only shown once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // an accepted request keeps the block busy and gives no result next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("request accepted without going busy");

    // a save never reports a hit
    a_save_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (done && req_reg.func == sahtr_pkg::FUNC_SAVE) |-> !rsp.hit)
        else $error("save reported a hit");

endmodule
